FILE: sv/ppa_pkg.sv
// ============================================================================
// ppa_pkg: shared types and constants for the physical page allocator
// Store depths, field widths, function and status codes, request/response
// structs.
// ============================================================================
`default_nettype none

package ppa_pkg;

    // Store depths
    localparam int FREE_PAGE_DEPTH = 256;
    localparam int BLOCK_DEPTH     = 64;

    // Address widths of the two stacks (top pointers are one bit wider)
    localparam int FP_AW  = $clog2(FREE_PAGE_DEPTH);
    localparam int BLK_AW = $clog2(BLOCK_DEPTH);

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int PAGE_W   = 52;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 64;

    // Full marks of the stacks
    localparam logic [FP_AW:0]  FP_FULL  = (FP_AW + 1)'(FREE_PAGE_DEPTH);
    localparam logic [BLK_AW:0] BLK_FULL = (BLK_AW + 1)'(BLOCK_DEPTH);

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_ADD_REGION   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC_PAGE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC_CONTIG = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FREE_PAGE    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FREE_PAGES   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [PAGE_W-1:0]  page_number;
        logic [COUNT_W-1:0] page_count;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   result_page;
        logic [STATUS_W-1:0] status;
        logic [USED_W-1:0]   pages_in_use;
    } rsp_t;

endpackage

`default_nettype wire

FILE: sv/physical_page_allocator.sv
// ============================================================================
// physical_page_allocator: page-frame allocator with free-page stack
// A stack of freed single pages and a stack of free blocks (base, count).
// Single-page and first-fit contiguous allocation under a small sequencer.
// ============================================================================
//
//  channel    ports                  handshake
//  ---------  ---------------------  ------------------------------------------
//  request    start, busy, req       taken at a clock edge with start && !busy
//  response   done, rsp              one cycle, marked by done; cannot stall
//
//  Pushes, free_page, unused codes and allocations that fail at once are answered
//  from S_EXEC; a free-page pop is answered from S_FPOP. Allocations from the
//  block stack try the top entry in S_DROP, then walk the block store one entry
//  a cycle through its registered read port in S_SCAN.
//  Reset clears both top pointers and the page counter; the stores need none.
//  busy is high from the cycle after accept until done rises; no back-pressure.
//
`default_nettype none

module physical_page_allocator
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ppa_pkg::req_t req,
    output logic               done,
    output ppa_pkg::rsp_t      rsp
);

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_FPOP = 5'b00100,
        S_DROP = 5'b01000,
        S_SCAN = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    ppa_pkg::req_t req_reg, req_next;
    ppa_pkg::rsp_t rsp_reg, rsp_next;
    logic          done_reg, done_next;

    logic [ppa_pkg::FP_AW:0]        ftop_reg, ftop_next;
    logic [ppa_pkg::BLK_AW:0]       btop_reg, btop_next;
    logic [ppa_pkg::BLK_AW-1:0]     idx_reg, idx_next;
    logic [ppa_pkg::USED_W-1:0]     used_reg, used_next;

    // Stores
    logic [ppa_pkg::PAGE_W-1:0]  fp_mem   [ppa_pkg::FREE_PAGE_DEPTH];
    logic [ppa_pkg::PAGE_W-1:0]  base_mem [ppa_pkg::BLOCK_DEPTH];
    logic [ppa_pkg::COUNT_W-1:0] cnt_mem  [ppa_pkg::BLOCK_DEPTH];

    logic [ppa_pkg::PAGE_W-1:0]  fp_q;
    logic [ppa_pkg::PAGE_W-1:0]  base_q;
    logic [ppa_pkg::COUNT_W-1:0] cnt_q;

    logic                        fp_we;
    logic                        blk_we;
    logic [ppa_pkg::BLK_AW-1:0]  blk_waddr;
    logic [ppa_pkg::BLK_AW-1:0]  blk_raddr;
    logic [ppa_pkg::PAGE_W-1:0]  blk_wbase;
    logic [ppa_pkg::COUNT_W-1:0] blk_wcount;

    // Pointer arithmetic
    logic [ppa_pkg::FP_AW:0]  ftop_m1;
    logic [ppa_pkg::BLK_AW:0] btop_m1;
    logic [ppa_pkg::BLK_AW:0] btop_m2;

    // Shared carve unit: compare, base advance, count reduction
    logic [ppa_pkg::COUNT_W-1:0] carve_n;
    logic [ppa_pkg::PAGE_W-1:0]  carve_base;
    logic [ppa_pkg::COUNT_W-1:0] carve_count;
    logic                        carve_fit;
    logic                        is_page;

    assign ftop_m1 = ftop_reg - 1'b1;
    assign btop_m1 = btop_reg - 1'b1;
    assign btop_m2 = btop_reg - 2'd2;

    assign is_page     = (req_reg.func == ppa_pkg::FUNC_ALLOC_PAGE);
    assign carve_n     = is_page ? ppa_pkg::COUNT_W'(1) : req_reg.page_count;
    assign carve_fit   = (cnt_q >= carve_n);
    assign carve_base  = base_q + ppa_pkg::PAGE_W'(carve_n);
    assign carve_count = cnt_q - carve_n;

    // Sequencer and datapath control
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        ftop_next  = ftop_reg;
        btop_next  = btop_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        fp_we      = 1'b0;
        blk_we     = 1'b0;
        blk_waddr  = btop_reg[ppa_pkg::BLK_AW-1:0];
        blk_wbase  = req_reg.page_number;
        blk_wcount = req_reg.page_count;
        blk_raddr  = btop_m1[ppa_pkg::BLK_AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.func == ppa_pkg::FUNC_ALLOC_PAGE && ftop_reg != '0)
                        state_next = S_FPOP;
                    else if ((req.func == ppa_pkg::FUNC_ALLOC_PAGE ||
                              req.func == ppa_pkg::FUNC_ALLOC_CONTIG) && btop_reg != '0)
                        state_next = S_DROP;
                    else
                        state_next = S_EXEC;
                end
            end

            // Requests answered from S_EXEC: pushes, failed allocations, unused codes
            S_EXEC:
            begin
                done_next            = 1'b1;
                state_next           = S_IDLE;
                rsp_next.result_page = '0;
                rsp_next.status      = ppa_pkg::STATUS_OK;
                unique case (req_reg.func)
                    ppa_pkg::FUNC_ADD_REGION, ppa_pkg::FUNC_FREE_PAGES:
                    begin
                        if (btop_reg == ppa_pkg::BLK_FULL)
                            rsp_next.status = ppa_pkg::STATUS_FULL;
                        else
                        begin
                            blk_we    = 1'b1;
                            btop_next = btop_reg + 1'b1;
                            if (req_reg.func == ppa_pkg::FUNC_FREE_PAGES)
                                used_next = used_reg - ppa_pkg::USED_W'(req_reg.page_count);
                        end
                    end
                    ppa_pkg::FUNC_FREE_PAGE:
                    begin
                        if (ftop_reg == ppa_pkg::FP_FULL)
                            rsp_next.status = ppa_pkg::STATUS_FULL;
                        else
                        begin
                            fp_we     = 1'b1;
                            ftop_next = ftop_reg + 1'b1;
                            used_next = used_reg - 1'b1;
                        end
                    end
                    ppa_pkg::FUNC_ALLOC_PAGE, ppa_pkg::FUNC_ALLOC_CONTIG:
                        rsp_next.status = ppa_pkg::STATUS_OOM;
                    default:
                        rsp_next.status = ppa_pkg::STATUS_OK;
                endcase
            end

            // Pop a freed single page
            S_FPOP:
            begin
                done_next            = 1'b1;
                state_next           = S_IDLE;
                ftop_next            = ftop_m1;
                used_next            = used_reg + 1'b1;
                rsp_next.result_page = fp_q;
                rsp_next.status      = ppa_pkg::STATUS_OK;
            end

            // Top block is on the read port: drop it if empty, else try it
            S_DROP:
            begin
                if (cnt_q == '0)
                begin
                    btop_next = btop_m1;
                    blk_raddr = btop_m2[ppa_pkg::BLK_AW-1:0];
                    if (btop_m1 == '0)
                    begin
                        done_next            = 1'b1;
                        state_next           = S_IDLE;
                        rsp_next.result_page = '0;
                        rsp_next.status      = ppa_pkg::STATUS_OOM;
                    end
                end
                else if (carve_fit)
                begin
                    blk_we               = 1'b1;
                    blk_waddr            = btop_m1[ppa_pkg::BLK_AW-1:0];
                    blk_wbase            = carve_base;
                    blk_wcount           = carve_count;
                    if (is_page && carve_count == '0)
                        btop_next = btop_m1;
                    used_next            = used_reg + ppa_pkg::USED_W'(carve_n);
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                    rsp_next.result_page = base_q;
                    rsp_next.status      = ppa_pkg::STATUS_OK;
                end
                else if (btop_m1 == '0)
                begin
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                    rsp_next.result_page = '0;
                    rsp_next.status      = ppa_pkg::STATUS_OOM;
                end
                else
                begin
                    idx_next   = btop_m2[ppa_pkg::BLK_AW-1:0];
                    blk_raddr  = btop_m2[ppa_pkg::BLK_AW-1:0];
                    state_next = S_SCAN;
                end
            end

            // First-fit walk down the block stack, one entry a cycle
            S_SCAN:
            begin
                blk_raddr = idx_reg;
                if (carve_fit)
                begin
                    blk_we               = 1'b1;
                    blk_waddr            = idx_reg;
                    blk_wbase            = carve_base;
                    blk_wcount           = carve_count;
                    used_next            = used_reg + ppa_pkg::USED_W'(carve_n);
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                    rsp_next.result_page = base_q;
                    rsp_next.status      = ppa_pkg::STATUS_OK;
                end
                else if (idx_reg == '0)
                begin
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                    rsp_next.result_page = '0;
                    rsp_next.status      = ppa_pkg::STATUS_OOM;
                end
                else
                begin
                    idx_next  = idx_reg - 1'b1;
                    blk_raddr = idx_reg - 1'b1;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        if (done_next)
            rsp_next.pages_in_use = used_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            ftop_reg  <= '0;
            btop_reg  <= '0;
            idx_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ftop_reg  <= ftop_next;
            btop_reg  <= btop_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // Free-page stack memory, registered read at the current top
    always_ff @(posedge clk)
    begin
        if (fp_we)
            fp_mem[ftop_reg[ppa_pkg::FP_AW-1:0]] <= req_reg.page_number;
        fp_q <= fp_mem[ftop_m1[ppa_pkg::FP_AW-1:0]];
    end

    // Block store memories, registered read
    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            base_mem[blk_waddr] <= blk_wbase;
            cnt_mem[blk_waddr]  <= blk_wcount;
        end
        base_q <= base_mem[blk_raddr];
        cnt_q  <= cnt_mem[blk_raddr];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Checks
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a response");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_tops_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (ftop_reg <= ppa_pkg::FP_FULL) && (btop_reg <= ppa_pkg::BLK_FULL))
        else $error("stack top beyond depth");

    a_fail_zero_page: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ppa_pkg::STATUS_OK) |-> (rsp.result_page == '0))
        else $error("failed request returned a page");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ppa_pkg::STATUS_OK || rsp.status == ppa_pkg::STATUS_OOM ||
                  rsp.status == ppa_pkg::STATUS_FULL))
        else $error("undefined status code");

endmodule

`default_nettype wire
